// ===== rtl/cwst_pkg.sv =====
// ----------------------------------------------------------------------------
// cwst_pkg
// Shared types and constants of the counter wait slot table.
// ----------------------------------------------------------------------------
package cwst_pkg;

	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned THREAD_W = 8;
	localparam int unsigned CFG_W    = 4;
	localparam int unsigned STATUS_W = 2;

	// at most this many waiters are released by one wake request
	localparam int unsigned MAX_WAKE   = 8;
	localparam int unsigned WAKE_CNT_W = $clog2(MAX_WAKE);

	localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(8);

	typedef enum logic [STATUS_W-1:0] {
		ST_QUEUED    = 2'd0,
		ST_SATISFIED = 2'd1,
		ST_FULL      = 2'd2,
		ST_READY     = 2'd3
	} status_t;

	// broadcast control from the sequencer to every slot cell
	typedef struct packed {
		logic add_wr;      // store the pending waiter in the lowest free slot
		logic load_match;  // latch target compare against the wake value
		logic drain;       // release the lowest matching slot
	} cell_ctrl_t;

endpackage

// ===== rtl/cwst_cell.sv =====
// ----------------------------------------------------------------------------
// cwst_cell
// One wait slot: holds a waiter and joins the free-slot and match priority
// chains that run from slot 0 upward.
// ----------------------------------------------------------------------------
module cwst_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cwst_pkg::cell_ctrl_t              ctrl,
	input  logic                              en,
	input  logic [cwst_pkg::HANDLE_W-1:0]     wr_handle,
	input  logic [cwst_pkg::COUNT_W-1:0]      wr_target,
	input  logic [cwst_pkg::THREAD_W-1:0]     wr_thread,
	input  logic [cwst_pkg::COUNT_W-1:0]      cmp_value,
	input  logic                              taken_in,
	output logic                              taken_out,
	input  logic                              picked_in,
	output logic                              picked_out,
	output logic                              grant,
	output logic                              pick,
	output logic [cwst_pkg::HANDLE_W-1:0]     rd_handle,
	output logic [cwst_pkg::THREAD_W-1:0]     rd_thread,
	output logic                              match_left
);

	logic                          busy_q;
	logic                          match_q;
	logic [cwst_pkg::HANDLE_W-1:0] handle_q;
	logic [cwst_pkg::COUNT_W-1:0]  target_q;
	logic [cwst_pkg::THREAD_W-1:0] thread_q;
	logic                          free;

	assign free       = en && !busy_q;
	assign taken_out  = taken_in || free;
	assign grant      = ctrl.add_wr && free && !taken_in;

	assign picked_out = picked_in || match_q;
	assign pick       = ctrl.drain && match_q && !picked_in;
	assign match_left = match_q && !pick;

	assign rd_handle  = pick ? handle_q : '0;
	assign rd_thread  = pick ? thread_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (grant) begin
				busy_q <= 1'b1;
			end else if (pick) begin
				busy_q <= 1'b0;
			end
			if (ctrl.load_match) begin
				match_q <= en && busy_q && (target_q == cmp_value);
			end else if (pick) begin
				match_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grant) begin
			handle_q <= wr_handle;
			target_q <= wr_target;
			thread_q <= wr_thread;
		end
	end

endmodule

// ===== rtl/counter_wait_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// counter_wait_slot_table_core
// Wait table of a synchronization counter built as a row of slot cells.
// ----------------------------------------------------------------------------
// One request is handled at a time. When the output register is free, an
// add claims the lowest free slot in use, unless the target is already
// reached, and loads the queued, satisfied or full status into the output
// register. A wake first latches the target compare in every cell, then
// releases one waiter per cycle, lowest slot first, up to eight; a wake
// that matches nothing returns to idle with no result. The output
// register sets the drain rate: while it is stalled the table waits.
module counter_wait_slot_table_core #(
	parameter int unsigned WAIT_SLOTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [cwst_pkg::CFG_W-1:0]        cfg_wdata,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [cwst_pkg::HANDLE_W-1:0]     waiter_handle,
	input  logic [cwst_pkg::COUNT_W-1:0]      target_count,
	input  logic [cwst_pkg::THREAD_W-1:0]     pinned_thread,
	input  logic [cwst_pkg::COUNT_W-1:0]      counter_value,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cwst_pkg::STATUS_W-1:0]     status,
	output logic [cwst_pkg::HANDLE_W-1:0]     ready_handle,
	output logic [cwst_pkg::THREAD_W-1:0]     ready_thread,
	output logic                              last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_MATCH,
		S_DRAIN
	} state_t;

	state_t                            state_q;
	logic [cwst_pkg::CFG_W-1:0]        slots_q;
	logic [cwst_pkg::WAKE_CNT_W-1:0]   wake_cnt_q;

	logic                              mode_q;
	logic [cwst_pkg::HANDLE_W-1:0]     handle_q;
	logic [cwst_pkg::COUNT_W-1:0]      target_q;
	logic [cwst_pkg::THREAD_W-1:0]     thread_q;
	logic [cwst_pkg::COUNT_W-1:0]      value_q;

	logic                              out_valid_q;
	cwst_pkg::status_t                 status_q;
	logic [cwst_pkg::HANDLE_W-1:0]     ready_handle_q;
	logic [cwst_pkg::THREAD_W-1:0]     ready_thread_q;
	logic                              last_q;

	cwst_pkg::cell_ctrl_t              ctrl;
	logic [WAIT_SLOTS-1:0]             en;
	logic [WAIT_SLOTS:0]               taken;
	logic [WAIT_SLOTS:0]               picked;
	logic [WAIT_SLOTS-1:0]             grant_vec;
	logic [WAIT_SLOTS-1:0]             pick_vec;
	logic [WAIT_SLOTS-1:0]             match_left_vec;
	logic [cwst_pkg::HANDLE_W-1:0]     cell_handle [WAIT_SLOTS];
	logic [cwst_pkg::THREAD_W-1:0]     cell_thread [WAIT_SLOTS];
	logic [cwst_pkg::HANDLE_W-1:0]     sel_handle;
	logic [cwst_pkg::THREAD_W-1:0]     sel_thread;

	logic                              out_free;
	logic                              out_load;
	logic                              reached;
	logic                              any_free;
	logic                              any_match;
	logic                              drain_go;
	logic                              drain_last;

	assign out_free   = !out_valid_q || !out_stall;
	assign reached    = (target_q == value_q);
	assign any_free   = taken[WAIT_SLOTS];
	assign any_match  = picked[WAIT_SLOTS];
	assign drain_go   = (state_q == S_DRAIN) && out_free && any_match;
	assign drain_last = !(|match_left_vec) ||
		(wake_cnt_q == cwst_pkg::WAKE_CNT_W'(cwst_pkg::MAX_WAKE - 1));
	assign out_load   = ((state_q == S_ADD) && out_free) || drain_go;

	assign ctrl.add_wr     = (state_q == S_ADD) && out_free && !reached;
	assign ctrl.load_match = (state_q == S_MATCH);
	assign ctrl.drain      = drain_go;

	assign taken[0]  = 1'b0;
	assign picked[0] = 1'b0;

	for (genvar i = 0; i < WAIT_SLOTS; i++) begin : g_cell
		assign en[i] = (32'(i) < 32'(slots_q));

		cwst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.en         (en[i]),
			.wr_handle  (handle_q),
			.wr_target  (target_q),
			.wr_thread  (thread_q),
			.cmp_value  (value_q),
			.taken_in   (taken[i]),
			.taken_out  (taken[i+1]),
			.picked_in  (picked[i]),
			.picked_out (picked[i+1]),
			.grant      (grant_vec[i]),
			.pick       (pick_vec[i]),
			.rd_handle  (cell_handle[i]),
			.rd_thread  (cell_thread[i]),
			.match_left (match_left_vec[i])
		);
	end

	// cells drive zero unless picked, so an OR selects the released waiter
	always_comb begin
		sel_handle = '0;
		sel_thread = '0;
		for (int i = 0; i < WAIT_SLOTS; i++) begin
			sel_handle = sel_handle | cell_handle[i];
			sel_thread = sel_thread | cell_thread[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= cwst_pkg::SLOTS_RESET;
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q   <= mode;
			handle_q <= waiter_handle;
			target_q <= target_count;
			thread_q <= pinned_thread;
			value_q  <= counter_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wake_cnt_q     <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= cwst_pkg::ST_QUEUED;
			ready_handle_q <= '0;
			ready_thread_q <= '0;
			last_q         <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= mode ? S_MATCH : S_ADD;
					end
				end
				S_ADD: begin
					if (out_free) begin
						ready_handle_q <= '0;
						ready_thread_q <= '0;
						last_q         <= 1'b1;
						if (reached) begin
							status_q <= cwst_pkg::ST_SATISFIED;
						end else if (any_free) begin
							status_q <= cwst_pkg::ST_QUEUED;
						end else begin
							status_q <= cwst_pkg::ST_FULL;
						end
						state_q <= S_IDLE;
					end
				end
				S_MATCH: begin
					wake_cnt_q <= '0;
					state_q    <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!any_match) begin
						state_q <= S_IDLE;
					end else if (drain_go) begin
						status_q       <= cwst_pkg::ST_READY;
						ready_handle_q <= sel_handle;
						ready_thread_q <= sel_thread;
						last_q         <= drain_last;
						wake_cnt_q     <= wake_cnt_q + 1'b1;
						if (drain_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign ready_handle = ready_handle_q;
	assign ready_thread = ready_thread_q;
	assign last         = last_q;

`ifndef SYNTH
	// the free-slot chain never claims two slots at once
	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_vec))
		else $error("more than one slot claimed by one add");

	// the match chain releases at most one waiter per cycle
	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick_vec))
		else $error("more than one slot released in one cycle");

	// a release always shows up as a ready result
	a_pick_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(|pick_vec) |=> (out_valid && status == cwst_pkg::ST_READY))
		else $error("released slot did not produce a ready result");

	// slots are only claimed while an add request is pending
	a_grant_add: assert property (@(posedge clk) disable iff (!arst_n)
		(|grant_vec) |-> (state_q == S_ADD && !mode_q))
		else $error("slot claimed outside an add request");
`endif

endmodule
